// ===== src/buddy_memory_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Buddy allocator assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BUDDY_MEMORY_ALLOCATOR_DEFINES_SVH
`define BUDDY_MEMORY_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BMA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bma_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator package
// Types, widths and codes shared by the allocator RTL.
// ----------------------------------------------------------------------------
package bma_pkg;

    localparam int unsigned POOL_BYTES_DEF = 4096;
    localparam int unsigned ORD_W          = 5;
    localparam int unsigned CNT_W          = 17;
    localparam int unsigned SIZE_W         = 13;
    localparam int unsigned OFF_W          = 12;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_A_RD   = 10'b0000000100,
        S_A_CHK  = 10'b0000001000,
        S_SPLIT  = 10'b0000010000,
        S_F_RD   = 10'b0000100000,
        S_F_CHK  = 10'b0001000000,
        S_M_RD   = 10'b0010000000,
        S_M_CHK  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic              start;
        logic [ORD_W-1:0]  order;
        logic [SIZE_W-1:0] req;
    } entry_t;

endpackage

// ===== src/buddy_memory_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy memory allocator
// First-fit buddy allocator over a power-of-two pool, one request at a time.
// ----------------------------------------------------------------------------
// Each request walks a block table (one entry per pool byte: start flag,
// order, recorded request) through one read port and one write port. An
// allocate reads and checks each block in address order, halves the chosen
// block while the half still fits, then records it. A free reads and checks
// the entry, then reads and checks the buddy for each merge step and for the
// last buddy check, which is skipped once the block is the whole pool. Every
// request then passes through the done state, where it waits while the
// output register is held, and through idle before the next request is
// taken. After reset the table is swept clear before the first request is
// taken. The result stays in an output register while the next request may
// already enter.
`include "buddy_memory_allocator_defines.svh"

module buddy_memory_allocator #(
    parameter int unsigned POOL_BYTES = bma_pkg::POOL_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       mode,
    input  logic [bma_pkg::SIZE_W-1:0] request_size,
    input  logic [bma_pkg::OFF_W-1:0]  block_offset,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [bma_pkg::OFF_W-1:0]  alloc_offset,
    output logic [bma_pkg::SIZE_W-1:0] freed_size,
    output logic [bma_pkg::SIZE_W-1:0] bytes_in_use,
    output logic [bma_pkg::SIZE_W-1:0] peak_in_use,
    output logic [bma_pkg::SIZE_W-1:0] bytes_occupied,
    output logic [bma_pkg::SIZE_W-1:0] block_count
);
    import bma_pkg::*;

    localparam int unsigned ADDR_W = (POOL_BYTES > 2) ? $clog2(POOL_BYTES) : 1;

    entry_t mem [POOL_BYTES];
    entry_t rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ORD_W-1:0]  ord_reg, ord_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    status_t           st_reg, st_next;
    logic [OFF_W-1:0]  res_off_reg, res_off_next;
    logic [SIZE_W-1:0] res_freed_reg, res_freed_next;
    logic [CNT_W-1:0]  in_use_reg, in_use_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  blk_reg, blk_next;
    logic              out_valid_reg;

    logic [CNT_W-1:0]  bsize, half, size_ext, bs_e, pos_sum, off_ext;
    logic [ADDR_W-1:0] buddy;
    entry_t            e;

    assign bsize    = CNT_W'(1) << ord_reg;
    assign half     = bsize >> 1;
    assign size_ext = CNT_W'(size_reg);
    assign e        = rd_data_reg;
    assign bs_e     = CNT_W'(1) << e.order;
    assign pos_sum  = CNT_W'(pos_reg) + bs_e;
    assign off_ext  = CNT_W'(block_offset);
    assign buddy    = pos_reg ^ bsize[ADDR_W-1:0];

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        clr_next       = clr_reg;
        ord_next       = ord_reg;
        size_next      = size_reg;
        st_next        = st_reg;
        res_off_next   = res_off_reg;
        res_freed_next = res_freed_reg;
        in_use_next    = in_use_reg;
        peak_next      = peak_reg;
        occ_next       = occ_reg;
        blk_next       = blk_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = '0;
        mem_raddr      = pos_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == '0)
                begin
                    mem_wdata.start = 1'b1;
                    mem_wdata.order = ORD_W'(ADDR_W);
                end
                if (clr_reg == ADDR_W'(POOL_BYTES - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_off_next   = '0;
                    res_freed_next = '0;
                    size_next      = request_size;
                    if (!mode)
                    begin
                        pos_next = '0;
                        if (request_size == '0)
                        begin
                            st_next    = ST_NOFIT;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_A_RD;
                    end
                    else if (off_ext >= CNT_W'(POOL_BYTES))
                    begin
                        st_next    = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pos_next   = off_ext[ADDR_W-1:0];
                        state_next = S_F_RD;
                    end
                end
            end
            S_A_RD:
                state_next = S_A_CHK;
            S_A_CHK:
            begin
                if (e.req == '0 && bs_e >= size_ext)
                begin
                    ord_next   = e.order;
                    state_next = S_SPLIT;
                end
                else if (pos_sum >= CNT_W'(POOL_BYTES))
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next   = pos_sum[ADDR_W-1:0];
                    state_next = S_A_RD;
                end
            end
            S_SPLIT:
            begin
                mem_we = 1'b1;
                if (ord_reg != '0 && half >= size_ext)
                begin
                    // free the upper half, keep the lower
                    mem_waddr       = pos_reg + half[ADDR_W-1:0];
                    mem_wdata.start = 1'b1;
                    mem_wdata.order = ord_reg - 1'b1;
                    ord_next        = ord_reg - 1'b1;
                    blk_next        = blk_reg + 1'b1;
                end
                else
                begin
                    mem_wdata.start = 1'b1;
                    mem_wdata.order = ord_reg;
                    mem_wdata.req   = size_reg;
                    in_use_next     = in_use_reg + size_ext;
                    occ_next        = occ_reg + bsize;
                    if (in_use_next > peak_reg)
                        peak_next = in_use_next;
                    res_off_next    = OFF_W'(pos_reg);
                    st_next         = ST_OK;
                    state_next      = S_DONE;
                end
            end
            S_F_RD:
                state_next = S_F_CHK;
            S_F_CHK:
            begin
                if (!e.start || e.req == '0)
                begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    res_freed_next = e.req;
                    in_use_next    = in_use_reg - CNT_W'(e.req);
                    occ_next       = occ_reg - bs_e;
                    ord_next       = e.order;
                    state_next     = S_M_RD;
                end
            end
            S_M_RD:
            begin
                mem_raddr = buddy;
                if (ord_reg < ORD_W'(ADDR_W))
                    state_next = S_M_CHK;
                else
                begin
                    mem_we          = 1'b1;
                    mem_wdata.start = 1'b1;
                    mem_wdata.order = ord_reg;
                    st_next         = ST_OK;
                    state_next      = S_DONE;
                end
            end
            S_M_CHK:
            begin
                mem_we = 1'b1;
                if (e.start && e.order == ord_reg && e.req == '0)
                begin
                    // drop the higher half; the lower entry is written at the end
                    mem_waddr  = (pos_reg < buddy) ? buddy : pos_reg;
                    pos_next   = (pos_reg < buddy) ? pos_reg : buddy;
                    ord_next   = ord_reg + 1'b1;
                    blk_next   = blk_reg - 1'b1;
                    state_next = S_M_RD;
                end
                else
                begin
                    mem_wdata.start = 1'b1;
                    mem_wdata.order = ord_reg;
                    st_next         = ST_OK;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            in_use_reg    <= '0;
            peak_reg      <= '0;
            occ_reg       <= '0;
            blk_reg       <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            in_use_reg <= in_use_next;
            peak_reg   <= peak_next;
            occ_reg    <= occ_next;
            blk_reg    <= blk_next;
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        ord_reg       <= ord_next;
        size_reg      <= size_next;
        st_reg        <= st_next;
        res_off_reg   <= res_off_next;
        res_freed_reg <= res_freed_next;
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            status         <= st_reg;
            alloc_offset   <= res_off_reg;
            freed_size     <= res_freed_reg;
            bytes_in_use   <= in_use_reg[SIZE_W-1:0];
            peak_in_use    <= peak_reg[SIZE_W-1:0];
            bytes_occupied <= occ_reg[SIZE_W-1:0];
            block_count    <= blk_reg[SIZE_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;

    `BMA_ASSERT_IMPL(a_clear_blocks, clk, rst_n, state_reg == S_CLEAR, !in_ready,
        "request taken during table clear")
    `BMA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready,
        state_reg != S_IDLE, "accepted request did not start")
    `BMA_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid,
        status == ST_OK || status == ST_NOFIT || status == ST_NOTFOUND,
        "undefined status code")
    `BMA_ASSERT_IMPL(a_blocks_nonzero, clk, rst_n, 1'b1, blk_reg != '0,
        "block count reached zero")

endmodule

// ===== test/buddy_memory_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy memory allocator testbench
// Drives allocate and free requests through the valid/ready channels, tracks
// the block table in a local model and checks every result field in order.
// ----------------------------------------------------------------------------

class alloc_scoreboard;
    localparam int unsigned POOL = 4096;
    localparam int unsigned POOL_ORD = 12;

    bit                start_map[POOL];
    bit [4:0]          order_map[POOL];
    bit [12:0]         req_map[POOL];
    int unsigned       in_use, peak, occupied, blocks;
    bit [1:0]          exp_status[$];
    bit [11:0]         exp_offset[$];
    bit [12:0]         exp_freed[$];
    bit [12:0]         exp_in_use[$], exp_peak[$], exp_occ[$], exp_blocks[$];
    int unsigned       mismatches;
    bit [11:0]         live[$];

    function new();
        for (int i = 0; i < POOL; i++)
        begin
            start_map[i] = 0;
            order_map[i] = 0;
            req_map[i] = 0;
        end
        start_map[0] = 1;
        order_map[0] = 5'(POOL_ORD);
        in_use = 0;
        peak = 0;
        occupied = 0;
        blocks = 1;
        mismatches = 0;
    endfunction

    function int pending();
        return exp_status.size();
    endfunction

    // Predict the result of one accepted request and queue it.
    function void note_request(bit mode, bit [12:0] size, bit [11:0] offs);
        bit [1:0]    st;
        bit [11:0]   aoff;
        bit [12:0]   freed;
        int unsigned pos, ord, bsize, buddy, lo, hi;
        bit          found;
        st = bma_pkg::ST_OK;
        aoff = 0;
        freed = 0;
        found = 0;
        if (!mode)
        begin
            pos = 0;
            if (size != 0)
            begin
                while (pos < POOL && !found)
                begin
                    ord = order_map[pos];
                    bsize = 1 << ord;
                    if (req_map[pos] == 0 && bsize >= size)
                    begin
                        found = 1;
                        while (ord > 0 && (bsize >> 1) >= size)
                        begin
                            bsize >>= 1;
                            ord--;
                            start_map[pos + bsize] = 1;
                            order_map[pos + bsize] = 5'(ord);
                            req_map[pos + bsize] = 0;
                            blocks++;
                        end
                        order_map[pos] = 5'(ord);
                        req_map[pos] = size;
                        in_use += size;
                        occupied += bsize;
                        if (in_use > peak)
                            peak = in_use;
                        aoff = 12'(pos);
                        live.push_back(12'(pos));
                    end
                    else
                        pos += bsize;
                end
            end
            if (!found)
                st = bma_pkg::ST_NOFIT;
        end
        else if (!start_map[offs] || req_map[offs] == 0)
            st = bma_pkg::ST_NOTFOUND;
        else
        begin
            pos = offs;
            ord = order_map[pos];
            bsize = 1 << ord;
            freed = req_map[pos];
            in_use -= req_map[pos];
            occupied -= bsize;
            req_map[pos] = 0;
            foreach (live[i])
                if (live[i] == offs)
                begin
                    live.delete(i);
                    break;
                end
            while (ord < POOL_ORD)
            begin
                buddy = pos ^ bsize;
                if (!start_map[buddy] || order_map[buddy] != ord || req_map[buddy] != 0)
                    break;
                lo = pos < buddy ? pos : buddy;
                hi = pos < buddy ? buddy : pos;
                start_map[hi] = 0;
                order_map[hi] = 0;
                ord++;
                bsize <<= 1;
                order_map[lo] = 5'(ord);
                pos = lo;
                blocks--;
            end
        end
        exp_status.push_back(st);
        exp_offset.push_back(aoff);
        exp_freed.push_back(freed);
        exp_in_use.push_back(in_use[12:0]);
        exp_peak.push_back(peak[12:0]);
        exp_occ.push_back(occupied[12:0]);
        exp_blocks.push_back(blocks[12:0]);
    endfunction

    function void check_result(bit [1:0] st, bit [11:0] aoff, bit [12:0] fr,
                               bit [12:0] iu, bit [12:0] pk, bit [12:0] oc,
                               bit [12:0] bc);
        bit [1:0]  es;
        bit [11:0] eo;
        bit [12:0] ef, ei, ep, ec, eb;
        if (exp_status.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transfer: status %0d", st);
            return;
        end
        es = exp_status.pop_front();
        eo = exp_offset.pop_front();
        ef = exp_freed.pop_front();
        ei = exp_in_use.pop_front();
        ep = exp_peak.pop_front();
        ec = exp_occ.pop_front();
        eb = exp_blocks.pop_front();
        if (st !== es || aoff !== eo || fr !== ef || iu !== ei || pk !== ep ||
            oc !== ec || bc !== eb)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch exp st=%0d off=%0d fr=%0d iu=%0d pk=%0d oc=%0d bc=%0d",
                         es, eo, ef, ei, ep, ec, eb);
                $display("         got st=%0d off=%0d fr=%0d iu=%0d pk=%0d oc=%0d bc=%0d",
                         st, aoff, fr, iu, pk, oc, bc);
            end
        end
    endfunction
endclass

module buddy_memory_allocator_test;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [12:0] request_size;
    logic [11:0] block_offset;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [11:0] alloc_offset;
    logic [12:0] freed_size, bytes_in_use, peak_in_use, bytes_occupied, block_count;

    alloc_scoreboard board;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          recv_hold;
    int unsigned idle_cycles;

    buddy_memory_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .request_size(request_size), .block_offset(block_offset),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .alloc_offset(alloc_offset), .freed_size(freed_size),
        .bytes_in_use(bytes_in_use), .peak_in_use(peak_in_use),
        .bytes_occupied(bytes_occupied), .block_count(block_count)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Offer one request and hold it until the transfer; the caller drops valid.
    task automatic send_request(bit m, bit [12:0] sz, bit [11:0] off);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        mode <= m;
        request_size <= sz;
        block_offset <= off;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(m, sz, off);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic bit [12:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 13'($urandom_range(1, 64));
        else if (r < 85)
            return 13'($urandom_range(1, 512));
        else if (r < 95)
            return 13'($urandom_range(1, 4096));
        else
            return 13'($urandom_range(0, 8191));
    endfunction

    task automatic random_phase(int n);
        bit [11:0] off;
        for (int i = 0; i < n; i++)
        begin
            if (board.live.size() > 0 && ($urandom_range(99) < 45 || board.live.size() > 40))
            begin
                off = board.live[$urandom_range(board.live.size() - 1)];
                if ($urandom_range(99) < 8)
                    off = 12'($urandom_range(4095));
                send_request(1, 13'($urandom_range(8191)), off);
            end
            else if ($urandom_range(99) < 5)
                send_request(1, pick_size(), 12'($urandom_range(4095)));
            else
                send_request(0, pick_size(), 12'($urandom_range(4095)));
        end
    endtask

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 0;
        else
        begin
            if (out_valid && out_ready)
                board.check_result(status, alloc_offset, freed_size, bytes_in_use,
                                   peak_in_use, bytes_occupied, block_count);
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 50000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        board = new();
        rst_n = 0;
        in_valid = 0;
        mode = 0;
        request_size = 0;
        block_offset = 0;
        recv_hold = 0;
        idle_cycles = 0;
        send_idle_pct = 12;
        recv_idle_pct = 83;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, splits, merges, bad frees
        send_request(0, 0, 0);
        send_request(0, 8191, 0);
        send_request(0, 4097, 0);
        send_request(0, 4096, 0);
        send_request(0, 1, 0);
        send_request(1, 0, 0);
        send_request(1, 0, 0);
        send_request(0, 1, 4095);
        send_request(0, 1, 0);
        send_request(0, 2048, 0);
        send_request(0, 3, 0);
        send_request(1, 8191, 1);
        send_request(1, 0, 5);
        send_request(1, 0, 4095);
        send_request(1, 0, 2048);
        send_request(1, 0, 0);
        send_request(1, 0, 4);
        send_request(1, 0, 1);
        send_request(0, 2049, 0);
        send_request(1, 0, 0);
        send_request(0, 4096, 0);
        send_request(1, 0, 0);
        wait_drained();

        random_phase(550);
        send_idle_pct = 83;
        recv_idle_pct = 12;
        random_phase(550);

        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 1;
        fork
            begin
                repeat (2000) @(posedge clk);
                recv_hold = 0;
            end
            random_phase(20);
        join
        wait_drained();
        random_phase(560);

        wait_drained();
        repeat (200) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
